// File: sv/twl_pkg.sv
// Package for the text word wrap layout block: payload and configuration types,
// controller commands and status, sizing constants and small arithmetic helpers.
// Depends on nothing; every other file of the block imports it.
package twl_pkg;

	localparam int MAX_WORD = 32;
	localparam int IDX_W    = 16;
	localparam int PTR_W    = $clog2(MAX_WORD);
	localparam int LEN_W    = $clog2(MAX_WORD + 1);
	localparam int ENTRY_W  = 18;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int STEP_W   = 11;

	localparam logic [1:0] REG_WRAP_WIDTH  = 2'd0;
	localparam logic [1:0] REG_WRAP_ENABLE = 2'd1;
	localparam logic [1:0] REG_LINE_HEIGHT = 2'd2;

	localparam logic [14:0] WRAP_WIDTH_RESET  = 15'd32767;
	localparam logic        WRAP_ENABLE_RESET = 1'b0;
	localparam logic [15:0] LINE_HEIGHT_RESET = 16'd1024;
	localparam logic [STEP_W-1:0] LINE_STEP_RESET =
		STEP_W'((32'(LINE_HEIGHT_RESET) + 32) >> 6);

	typedef struct packed {
		logic [9:0]        advance;
		logic [9:0]        glyph_width;
		logic signed [7:0] kerning;
		logic              is_newline;
		logic              is_wordbreak;
		logic              end_of_text;
	} char_t;

	typedef struct packed {
		logic [IDX_W-1:0]   char_index;
		logic signed [15:0] pen_x;
		logic [15:0]        pen_y;
		logic               is_replacement;
		logic               is_cursor_end;
		logic               last;
	} place_t;

	typedef struct packed {
		logic [14:0]       wrap_width;
		logic              wrap_enable;
		logic [STEP_W-1:0] line_step;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REPLAY,
		ST_FINAL,
		ST_CURSOR
	} ctrl_state_t;

	typedef struct packed {
		logic place;
		logic start;
		logic replay;
		logic fin;
		logic cursor;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic move_word;
		logic replay_last;
		logic item_eot;
		logic held_eot;
	} status_t;

	function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
		input logic signed [16:0] b);
		logic signed [17:0] s;
		s = $signed({{2{a[15]}}, a}) + $signed({b[16], b});
		if (s > 18'sd32767) begin
			return 16'sh7fff;
		end else if (s < -18'sd32768) begin
			return 16'sh8000;
		end else begin
			return s[15:0];
		end
	endfunction

	function automatic logic signed [16:0] kern_ext(input logic [7:0] k);
		return $signed({{9{k[7]}}, k});
	endfunction

	function automatic logic signed [16:0] adv_ext(input logic [9:0] a);
		return $signed({7'b0, a});
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(MAX_WORD - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [15:0] next_line(input logic [15:0] y,
		input logic [STEP_W-1:0] step);
		logic [16:0] s;
		s = {1'b0, y} + 17'(step);
		return s[16] ? 16'hffff : s[15:0];
	endfunction

endpackage

// File: sv/text_word_wrap_layout.sv
// Top level of the text word wrap layout block: greedy word wrap of a character stream.
// Instantiates twl_cfg, twl_ctrl and twl_dp; depends on twl_pkg.
//
// Characters enter on the char channel (valid/ready) and placed positions leave on the
// place channel (valid/ready), one transaction per position, the last one of each
// character marked by its last bit. The APB-style port sets wrap width, wrap enable and
// line height; write it only while no character is in flight.
// A character that fits is accepted and its position loaded into the output register at
// that clock edge; a steady stream runs at one character per cycle while not stalled.
// When a character pushes its word past the wrap width, the stored word is emitted again
// from the word store memory, one position per cycle while the receiver takes them, and
// then the character itself is placed. An end-of-text character is followed by the cursor
// position, after which the layout state starts over for a new text.
// When the receiver holds place_ready low, the output register holds its transaction
// and char_ready stays low until the register drains.
// Reset clears the layout state and loads the register defaults; the word store needs
// no clearing pass, since only entries written for the current word are read.
module text_word_wrap_layout (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [twl_pkg::ADDR_W-1:0] paddr,
	input  logic [twl_pkg::DATA_W-1:0] pwdata,
	output logic [twl_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       char_valid,
	output logic                       char_ready,
	input  twl_pkg::char_t             char_data,
	output logic                       place_valid,
	input  logic                       place_ready,
	output twl_pkg::place_t            place_data
);
	import twl_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	twl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	twl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.status     (status),
		.cmd        (cmd)
	);

	twl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.status      (status),
		.char_data   (char_data),
		.place_valid (place_valid),
		.place_ready (place_ready),
		.place_data  (place_data)
	);

endmodule

// File: sv/twl_cfg.sv
// Configuration register file of the text word wrap layout block on an APB-style port.
// Holds wrap width, wrap enable and line height, plus the rounded line step.
// Depends on twl_pkg.
module twl_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [twl_pkg::ADDR_W-1:0] paddr,
	input  logic [twl_pkg::DATA_W-1:0] pwdata,
	output logic [twl_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output twl_pkg::cfg_t              cfg
);
	import twl_pkg::*;

	logic [14:0]       wrap_width_q;
	logic              wrap_enable_q;
	logic [15:0]       line_height_q;
	logic [STEP_W-1:0] line_step_q;
	logic              wr;
	logic [1:0]        idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_width_q  <= WRAP_WIDTH_RESET;
			wrap_enable_q <= WRAP_ENABLE_RESET;
			line_height_q <= LINE_HEIGHT_RESET;
			line_step_q   <= LINE_STEP_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_WRAP_WIDTH: begin
					wrap_width_q <= pwdata[14:0];
				end
				REG_WRAP_ENABLE: begin
					wrap_enable_q <= pwdata[0];
				end
				REG_LINE_HEIGHT: begin
					line_height_q <= pwdata[15:0];
					line_step_q   <= STEP_W'(({1'b0, pwdata[15:0]} + 17'd32) >> 6);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WRAP_WIDTH:  prdata = DATA_W'(wrap_width_q);
			REG_WRAP_ENABLE: prdata = DATA_W'(wrap_enable_q);
			REG_LINE_HEIGHT: prdata = DATA_W'(line_height_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.wrap_width  = wrap_width_q;
	assign cfg.wrap_enable = wrap_enable_q;
	assign cfg.line_step   = line_step_q;

endmodule

// File: sv/twl_ctrl.sv
// Controller state machine of the text word wrap layout block.
// Sequences placement, word replay, the moved character and the cursor end.
// Depends on twl_pkg.
module twl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	output logic             char_ready,
	input  twl_pkg::status_t status,
	output twl_pkg::cmd_t    cmd
);
	import twl_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		char_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				char_ready = status.slot_free;
				if (char_valid && status.slot_free) begin
					if (status.move_word) begin
						cmd.start = 1'b1;
						state_d   = ST_REPLAY;
					end else begin
						cmd.place = 1'b1;
						if (status.item_eot) begin
							state_d = ST_CURSOR;
						end
					end
				end
			end
			ST_REPLAY: begin
				if (status.slot_free) begin
					cmd.replay = 1'b1;
					if (status.replay_last) begin
						state_d = ST_FINAL;
					end
				end
			end
			ST_FINAL: begin
				if (status.slot_free) begin
					cmd.fin = 1'b1;
					state_d = status.held_eot ? ST_CURSOR : ST_IDLE;
				end
			end
			ST_CURSOR: begin
				if (status.slot_free) begin
					cmd.cursor = 1'b1;
					state_d    = ST_IDLE;
				end
			end
		endcase
	end

endmodule

// File: sv/twl_dp.sv
// Datapath of the text word wrap layout block: pen and word state, the circular
// word store memory, replay arithmetic and the output register.
// Depends on twl_pkg; driven by twl_ctrl through cmd_t and status_t.
module twl_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  twl_pkg::cfg_t    cfg,
	input  twl_pkg::cmd_t    cmd,
	output twl_pkg::status_t status,
	input  twl_pkg::char_t   char_data,
	output logic             place_valid,
	input  logic             place_ready,
	output twl_pkg::place_t  place_data
);
	import twl_pkg::*;

	logic signed [15:0] pen_x_q, pen_x_d;
	logic [15:0]        pen_y_q, pen_y_d;
	logic signed [15:0] wsx_q, wsx_d;
	logic [IDX_W-1:0]   wsi_q, wsi_d;
	logic [IDX_W-1:0]   cnt_q, cnt_d;
	logic [LEN_W-1:0]   wl_q, wl_d;
	logic [PTR_W-1:0]   head_q, head_d;
	logic [PTR_W-1:0]   tail_q, tail_d;
	logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
	logic [LEN_W-1:0]   rk_q, rk_d;
	logic [IDX_W-1:0]   ridx_q, ridx_d;
	logic signed [15:0] base_q, base_d;
	char_t              cur_q;
	place_t             out_q;
	logic               out_valid_q;
	logic [ENTRY_W-1:0] mem [MAX_WORD];
	logic [ENTRY_W-1:0] rdat_q;

	logic               skip;
	logic               keep;
	logic               over;
	logic signed [15:0] kx;
	logic signed [17:0] bound;
	logic [15:0]        nty;
	logic signed [15:0] pos;
	logic signed [15:0] tx;
	place_t             res;
	logic               ld;
	logic               clear;
	logic               push;
	logic               commit;
	logic               rd_en;
	logic [PTR_W-1:0]   rd_addr;
	logic [PTR_W-1:0]   head_e;
	logic [LEN_W-1:0]   wl_e;
	char_t              item;
	logic [ENTRY_W-1:0] wr_entry;

	assign skip  = (wsi_q == cnt_q);
	assign kx    = skip ? pen_x_q : sat_add(pen_x_q, kern_ext(char_data.kerning));
	assign bound = $signed({{2{kx[15]}}, kx}) + $signed({8'b0, char_data.glyph_width});
	assign over  = cfg.wrap_enable && (bound > $signed({3'b0, cfg.wrap_width}));
	assign keep  = !over || ((wsx_q == '0) && skip);
	assign nty   = next_line(pen_y_q, cfg.line_step);
	assign item  = cmd.fin ? cur_q : char_data;
	assign wr_entry = {item.kerning, item.advance};

	assign status.slot_free   = !out_valid_q || place_ready;
	assign status.move_word   = !char_data.is_newline && over && (wsx_q != '0) && (wl_q != '0);
	assign status.replay_last = ((rk_q + LEN_W'(1)) == wl_q);
	assign status.item_eot    = char_data.end_of_text;
	assign status.held_eot    = cur_q.end_of_text;

	always_comb begin
		pen_x_d  = pen_x_q;
		pen_y_d  = pen_y_q;
		wsx_d    = wsx_q;
		wsi_d    = wsi_q;
		cnt_d    = cnt_q;
		rd_ptr_d = rd_ptr_q;
		rk_d     = rk_q;
		ridx_d   = ridx_q;
		base_d   = base_q;
		res      = '0;
		ld       = 1'b0;
		clear    = 1'b0;
		push     = 1'b0;
		commit   = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = rd_ptr_q;
		pos      = '0;
		tx       = pen_x_q;

		if (cmd.place) begin
			ld             = 1'b1;
			cnt_d          = cnt_q + IDX_W'(1);
			res.char_index = cnt_q;
			res.last       = !char_data.end_of_text;
			if (char_data.is_newline) begin
				res.pen_x = pen_x_q;
				res.pen_y = pen_y_q;
				pen_x_d   = '0;
				pen_y_d   = nty;
				wsx_d     = '0;
				wsi_d     = cnt_q + IDX_W'(1);
				clear     = 1'b1;
			end else begin
				commit = 1'b1;
				if (keep) begin
					res.pen_x = kx;
					res.pen_y = pen_y_q;
					tx        = sat_add(kx, adv_ext(char_data.advance));
				end else begin
					res.pen_x = '0;
					res.pen_y = nty;
					tx        = $signed({6'b0, char_data.advance});
					pen_y_d   = nty;
					wsx_d     = '0;
					if (wsx_q == '0) begin
						wsi_d = cnt_q;
						clear = 1'b1;
					end
				end
			end
		end else if (cmd.start) begin
			pen_y_d  = nty;
			wsx_d    = '0;
			rd_en    = 1'b1;
			rd_addr  = head_q;
			rd_ptr_d = ptr_inc(head_q);
			rk_d     = '0;
			ridx_d   = cnt_q - IDX_W'(wl_q);
		end else if (cmd.replay) begin
			ld                 = 1'b1;
			pos                = (rk_q == '0) ? 16'sd0 : sat_add(base_q, kern_ext(rdat_q[17:10]));
			res.char_index     = ridx_q;
			res.pen_x          = pos;
			res.pen_y          = pen_y_q;
			res.is_replacement = 1'b1;
			base_d             = sat_add(pos, adv_ext(rdat_q[9:0]));
			rd_en              = 1'b1;
			rd_ptr_d           = ptr_inc(rd_ptr_q);
			rk_d               = rk_q + LEN_W'(1);
			ridx_d             = ridx_q + IDX_W'(1);
		end else if (cmd.fin) begin
			ld             = 1'b1;
			pos            = sat_add(base_q, kern_ext(cur_q.kerning));
			res.char_index = cnt_q;
			res.pen_x      = pos;
			res.pen_y      = pen_y_q;
			res.last       = !cur_q.end_of_text;
			tx             = sat_add(pos, adv_ext(cur_q.advance));
			cnt_d          = cnt_q + IDX_W'(1);
			commit         = 1'b1;
		end else if (cmd.cursor) begin
			ld                = 1'b1;
			res.char_index    = cnt_q;
			res.pen_x         = pen_x_q;
			res.pen_y         = pen_y_q;
			res.is_cursor_end = 1'b1;
			res.last          = 1'b1;
			pen_x_d           = '0;
			pen_y_d           = '0;
			wsx_d             = '0;
			wsi_d             = '0;
			cnt_d             = '0;
			clear             = 1'b1;
		end

		if (commit) begin
			pen_x_d = tx;
			if (item.is_wordbreak) begin
				wsx_d = tx;
				wsi_d = cnt_q + IDX_W'(1);
				clear = 1'b1;
			end else begin
				push = 1'b1;
			end
		end

		head_e = clear ? tail_q : head_q;
		wl_e   = clear ? '0 : wl_q;
		tail_d = tail_q;
		head_d = head_e;
		wl_d   = wl_e;
		if (push) begin
			tail_d = ptr_inc(tail_q);
			if (wl_e == LEN_W'(MAX_WORD)) begin
				head_d = ptr_inc(head_e);
			end else begin
				wl_d = wl_e + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			wsx_q       <= '0;
			wsi_q       <= '0;
			cnt_q       <= '0;
			wl_q        <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			rd_ptr_q    <= '0;
			rk_q        <= '0;
			ridx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pen_x_q  <= pen_x_d;
			pen_y_q  <= pen_y_d;
			wsx_q    <= wsx_d;
			wsi_q    <= wsi_d;
			cnt_q    <= cnt_d;
			wl_q     <= wl_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			rd_ptr_q <= rd_ptr_d;
			rk_q     <= rk_d;
			ridx_q   <= ridx_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (place_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		base_q <= base_d;
		if (cmd.start) begin
			cur_q <= char_data;
		end
		if (ld) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= wr_entry;
		end
		if (rd_en) begin
			rdat_q <= mem[rd_addr];
		end
	end

	assign place_valid = out_valid_q;
	assign place_data  = out_q;

endmodule
